### src/bitmap_block_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// bitmap block allocator assertion macros
// shared property forms for the allocator checks
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define BBA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared types, constants and encoders of the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAP_BYTES_DEF = 256;
    localparam int SCAN_LIMIT    = 256;
    localparam int GRP_BYTES     = 16;
    localparam int GRP_COUNT     = SCAN_LIMIT / GRP_BYTES;
    localparam int GRP_IDX_W     = $clog2(GRP_COUNT);
    localparam int BYTE_W        = 8;
    localparam int BIT_IDX_W     = 3;
    localparam int BLOCK_W       = 11;
    localparam int IN_DATA_W     = 32;
    localparam int IN_USER_W     = 2;
    localparam int OUT_DATA_W    = 24;
    localparam int OUT_USER_W    = 1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_LOAD    = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GROUP,
        ST_BYTE,
        ST_READ,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic capture;
        logic clr_en;
        logic grp_en;
        logic byte_en;
        logic rd_en;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic clr_last;
        op_t  in_op;
        logic found;
        logic out_free;
    } ctl_status_t;

    // position of the lowest clear bit
    function automatic logic [3:0] first_zero16(input logic [15:0] v);
        logic [3:0] pos;
        pos = '0;
        for (int i = 15; i >= 0; i--)
        begin
            if (!v[i])
            begin
                pos = 4'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic [BIT_IDX_W-1:0] first_zero8(input logic [BYTE_W-1:0] v);
        logic [BIT_IDX_W-1:0] pos;
        pos = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                pos = BIT_IDX_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

### src/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// sequencer of the allocator: clearing pass, scan, read and update steps
// ----------------------------------------------------------------------------
module bba_ctrl
    import bba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ctl_status_t status,
    output ctl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (status.in_op)
                        OP_ALLOC:   state_next = ST_GROUP;
                        OP_LOAD:    state_next = ST_UPDATE;
                        OP_RELEASE: state_next = ST_READ;
                        OP_READ:    state_next = ST_READ;
                        default:    state_next = ST_READ;
                    endcase
                end
            end
            ST_GROUP:
            begin
                state_next = ST_BYTE;
            end
            ST_BYTE:
            begin
                state_next = status.found ? ST_READ : ST_UPDATE;
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_GROUP:
            begin
                cmd.grp_en = 1'b1;
            end
            ST_BYTE:
            begin
                cmd.byte_en = 1'b1;
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### src/bba_datapath.sv
// ----------------------------------------------------------------------------
// bba_datapath
// bitmap memory, full-byte summary, two-level first-fit search and result word
// ----------------------------------------------------------------------------
module bba_datapath
    import bba_pkg::*;
#(
    parameter int MAP_BYTES = MAP_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  in_data,   // block_number, map_index, map_value
    input  logic [IN_USER_W-1:0]  in_user,   // operation
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,  // allocated_block, map_data, zero pad
    output logic [OUT_USER_W-1:0] out_user,  // map_full
    input  ctl_cmd_t              cmd,
    output ctl_status_t           status
);

    localparam int ADDR_W     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int SCAN_BYTES = (MAP_BYTES < SCAN_LIMIT) ? MAP_BYTES : SCAN_LIMIT;
    localparam int SCAN_W     = (SCAN_BYTES > 1) ? $clog2(SCAN_BYTES) : 1;

    logic [BYTE_W-1:0] mem [MAP_BYTES];

    op_t                  op_reg;
    logic [BLOCK_W-1:0]   bn_reg;
    logic [BYTE_W-1:0]    idx_reg;
    logic [BYTE_W-1:0]    val_reg;

    logic [SCAN_BYTES-1:0] full_reg;
    logic [SCAN_LIMIT-1:0] full_pad;
    logic [GRP_COUNT-1:0]  grp_full;
    logic [GRP_IDX_W-1:0]  grp_sel_reg;
    logic                  found_reg;
    logic [BYTE_W-1:0]     scan_byte_reg;
    logic [GRP_BYTES-1:0]  grp_row;

    logic [ADDR_W-1:0]     clr_cnt_reg;
    logic [BYTE_W-1:0]     rd_data_reg;

    logic [BYTE_W-1:0]     op_byte;
    logic                  in_range;
    logic [ADDR_W-1:0]     mem_addr;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [BYTE_W-1:0]     upd_data;
    logic [BYTE_W-1:0]     mem_wdata;
    logic                  upd_we;
    logic                  mem_we;
    logic [BIT_IDX_W-1:0]  free_bit;

    logic                  out_valid_reg;
    logic [BLOCK_W-1:0]    alloc_reg;
    logic                  full_flag_reg;
    logic [BYTE_W-1:0]     data_reg;

    // captured request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op_t'(in_user);
            bn_reg  <= in_data[10:0];
            idx_reg <= in_data[18:11];
            val_reg <= in_data[26:19];
        end
    end

    // summary of full bytes, padded with full bytes above the scan reach
    always_comb
    begin
        full_pad                 = '1;
        full_pad[SCAN_BYTES-1:0] = full_reg;
        for (int g = 0; g < GRP_COUNT; g++)
        begin
            grp_full[g] = &full_pad[g*GRP_BYTES +: GRP_BYTES];
        end
        grp_row = full_pad[{grp_sel_reg, 4'b0000} +: GRP_BYTES];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.grp_en)
        begin
            grp_sel_reg <= first_zero16(grp_full);
            found_reg   <= ~&grp_full;
        end
        if (cmd.byte_en)
        begin
            scan_byte_reg <= {grp_sel_reg, first_zero16(grp_row)};
        end
    end

    always_comb
    begin
        unique case (op_reg)
            OP_ALLOC:   op_byte = scan_byte_reg;
            OP_RELEASE: op_byte = bn_reg[BLOCK_W-1:BIT_IDX_W];
            default:    op_byte = idx_reg;
        endcase
        in_range = (32'(op_byte) < MAP_BYTES);
        mem_addr = ADDR_W'(op_byte);
        free_bit = first_zero8(rd_data_reg);
        unique case (op_reg)
            OP_ALLOC:   upd_data = rd_data_reg | (BYTE_W'(1) << free_bit);
            OP_RELEASE: upd_data = rd_data_reg & ~(BYTE_W'(1) << bn_reg[BIT_IDX_W-1:0]);
            OP_LOAD:    upd_data = val_reg;
            default:    upd_data = rd_data_reg;
        endcase
        if (op_reg == OP_ALLOC)
        begin
            upd_we = cmd.out_load && found_reg;
        end
        else
        begin
            upd_we = cmd.out_load && (op_reg != OP_READ) && in_range;
        end
        mem_we    = cmd.clr_en || upd_we;
        mem_waddr = cmd.clr_en ? clr_cnt_reg : mem_addr;
        mem_wdata = cmd.clr_en ? '0 : upd_data;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            full_reg    <= '0;
        end
        else
        begin
            if (cmd.clr_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (upd_we && (32'(op_byte) < SCAN_BYTES))
            begin
                full_reg[SCAN_W'(op_byte)] <= (upd_data == '1);
            end
        end
    end

    // result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            alloc_reg     <= ((op_reg == OP_ALLOC) && found_reg) ?
                             {scan_byte_reg, free_bit} : '0;
            full_flag_reg <= (op_reg == OP_ALLOC) && !found_reg;
            data_reg      <= ((op_reg == OP_READ) && in_range) ? rd_data_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(OUT_DATA_W - BLOCK_W - BYTE_W){1'b0}}, data_reg, alloc_reg};
    assign out_user  = full_flag_reg;

    assign status.clr_last = (clr_cnt_reg == ADDR_W'(MAP_BYTES - 1));
    assign status.in_op    = op_t'(in_user);
    assign status.found    = found_reg;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

### src/bitmap_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// allocate: group search, byte search, map read, update; a full map skips the map read
// release and read: map read, update; load: update only
// one word at a time; the update step waits while a previous result is not taken
// reset: a clearing pass zeroes the map, s_tready stays low meanwhile
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit
    import bba_pkg::*;
#(
    parameter int MAP_BYTES = MAP_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // block_number, map_index, map_value, zero pad
    input  logic [IN_USER_W-1:0]  s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // allocated_block, map_data, zero pad
    output logic [OUT_USER_W-1:0] m_tuser    // map_full
);

    `include "bitmap_block_allocator_unit_defines.svh"

    ctl_cmd_t    cmd;
    ctl_status_t status;

    bba_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bba_datapath #(
        .MAP_BYTES (MAP_BYTES)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

    `BBA_ASSERT_IMPLY(a_no_accept_in_clear, cmd.clr_en, !s_tready, "word accepted during clearing")
    `BBA_ASSERT_IMPLY(a_load_slot_free, cmd.out_load, (!m_tvalid || m_tready), "result overwritten")
    `BBA_ASSERT_NEXT(a_one_in_flight, (s_tvalid && s_tready), !s_tready, "second word taken")
    `BBA_ASSERT_IMPLY(a_full_has_no_block, (m_tvalid && m_tuser[0]), (m_tdata[10:0] == '0), "full with block")

endmodule
